>>> hw/rtl/smtd_pkg.sv
// Package with the shared constants, types and helpers of the step matrix multi-tap delay.
package smtd_pkg;

    localparam int MAX_STEPS    = 32;
    localparam int BUFFER_DEPTH = 262144;

    localparam int STEP_W  = $clog2(MAX_STEPS);
    localparam int N_W     = STEP_W + 1;
    localparam int BUF_AW  = $clog2(BUFFER_DEPTH);
    localparam int LEN_W   = BUF_AW + 1;
    localparam int DIV_W   = LEN_W + STEP_W;
    localparam int GAIN_AW = 2 * STEP_W;
    localparam int PROD_W  = 32 + N_W;
    localparam int ACC_W   = 46;

    localparam logic [15:0] UNITY_GAIN = 16'd32768;

    // Opcodes of an input transaction.
    localparam logic [1:0] OP_AUDIO = 2'd0;
    localparam logic [1:0] OP_GAIN  = 2'd1;
    localparam logic [1:0] OP_PHASE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NR_STEPS = 2'd0;
    localparam logic [1:0] CFG_PLAY     = 2'd1;
    localparam logic [1:0] CFG_LOOP_LEN = 2'd2;
    localparam logic [1:0] CFG_PHASE_INC = 2'd3;

    // One write request into the gain matrix.
    typedef struct packed {
        logic              en;
        logic [STEP_W-1:0] row;
        logic [STEP_W-1:0] col;
        logic [15:0]       level;
    } t_gain_wr;

    // True when a requested gain exceeds unity.
    function automatic logic gain_over(input logic [15:0] level);
        return level > UNITY_GAIN;
    endfunction

endpackage

>>> hw/rtl/step_matrix_multitap_delay.sv
// Top level of the stereo step-sequenced multi-tap delay.
//
// Input channel i_valid/o_stall carries one transaction per item: an audio
// sample, a gain matrix write or a phase load. Output channel o_valid/i_stall
// returns exactly one result per input transaction, in order.
// An audio item is accepted; with play set, 32 gain reads are then issued
// back to back through the gain memory port and feed the ring read,
// multiply and accumulate pipeline, while with play off the sum stays zero;
// rounding and the output load follow. Other opcodes return a zero sample.
// The walk over the matrix rows through the single gain and ring read ports
// sets the audio throughput; one item is in work at a time.
// After reset all 1024 gain matrix entries are swept, then a tap table is
// built in 32 divisions; o_stall stays high meanwhile. Writing the step
// count or the loop length rebuilds the table the same way.
// The ring buffer needs no clearing: unwritten entries read as zero.
// A finished result waits in the output register while i_stall is high; the
// next input transaction is still taken and is held at its end until free.
// Configuration is a plain write port i_cfg_we/i_cfg_idx/i_cfg_data.
module step_matrix_multitap_delay
    import smtd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [23:0] i_left_in,
    input  logic signed [23:0] i_right_in,
    input  logic [4:0]         i_gain_row,
    input  logic [4:0]         i_gain_column,
    input  logic [15:0]        i_gain_level,
    input  logic [31:0]        i_new_phase,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [23:0] o_left_out,
    output logic signed [23:0] o_right_out,
    output logic [4:0]         o_current_step,
    output logic               o_gain_clamped,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_BUILD = 7'b0000010,
        S_IDLE  = 7'b0000100,
        S_WALK  = 7'b0001000,
        S_MIX   = 7'b0010000,
        S_INFO  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [N_W-1:0]   r_nr_steps;
    logic             r_play;
    logic [LEN_W-1:0] r_loop_len;
    logic [31:0]      r_phase_inc;
    logic             r_dirty;

    logic [31:0]      r_phase;
    logic [N_W-1:0]   n_eff;
    logic [LEN_W-1:0] len_eff;
    logic [PROD_W-1:0] phase_prod;
    logic [STEP_W-1:0] step_now;

    // Tap table: quotient and inexact flag of len*d/n for each step distance.
    logic [BUF_AW-1:0] r_tap_q  [MAX_STEPS];
    logic              r_tap_nz [MAX_STEPS];
    logic [STEP_W-1:0] r_build_d;
    logic [STEP_W-1:0] div_d;
    logic              div_start;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;
    logic              div_rem_nz;

    // Item state.
    logic              accept;
    logic [STEP_W-1:0] r_step;
    logic [BUF_AW-1:0] r_base;
    logic              r_clamp;
    logic [N_W-1:0]    r_row_cnt;
    logic              issue;

    // Walk pipeline.
    logic              r_v1, r_v2, r_v3;
    logic [STEP_W-1:0] r_row1;
    logic [15:0]       r_g2;
    logic signed [40:0] r_pl, r_pr;
    logic signed [ACC_W-1:0] r_acc_l, r_acc_r;

    // Result and output registers.
    logic signed [23:0] r_res_l, r_res_r;
    logic               r_out_valid;
    logic signed [23:0] r_out_l, r_out_r;
    logic [STEP_W-1:0]  r_out_step;
    logic               r_out_clamp;
    logic               out_free;

    // Memory connections.
    t_gain_wr          gain_wr;
    logic [15:0]       gain_rd;
    logic              gain_busy;
    logic              ring_we;
    logic [BUF_AW-1:0] ring_idx;
    logic [23:0]       ring_l, ring_r;
    logic [BUF_AW-1:0] ring_wp;

    // Tap distance logic.
    logic [N_W:0]       s_x, r_x, sn_x, d_x;
    logic               tap_fwd;
    logic [STEP_W-1:0]  tap_d;
    logic [LEN_W-1:0]   tap_back;

    // Effective step count and loop length.
    always_comb begin
        if (r_nr_steps == '0) begin
            n_eff = N_W'(1);
        end else if (r_nr_steps > N_W'(MAX_STEPS)) begin
            n_eff = N_W'(MAX_STEPS);
        end else begin
            n_eff = r_nr_steps;
        end
        len_eff = (r_loop_len > LEN_W'(BUFFER_DEPTH)) ? LEN_W'(BUFFER_DEPTH) : r_loop_len;
    end

    // Playing step from the loop phase.
    assign phase_prod = PROD_W'(r_phase) * PROD_W'(n_eff);
    assign step_now   = phase_prod[32 +: STEP_W];

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || r_dirty;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nr_steps  <= N_W'(MAX_STEPS);
            r_play      <= 1'b0;
            r_loop_len  <= '0;
            r_phase_inc <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NR_STEPS:  r_nr_steps  <= i_cfg_data[N_W-1:0];
                CFG_PLAY:      r_play      <= i_cfg_data[0];
                CFG_LOOP_LEN:  r_loop_len  <= i_cfg_data[LEN_W-1:0];
                CFG_PHASE_INC: r_phase_inc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Table build divider.
    assign div_start = (r_state == S_IDLE && r_dirty) ||
                       (r_state == S_BUILD && div_done && r_build_d != STEP_W'(MAX_STEPS - 1));
    assign div_d     = (r_state == S_IDLE) ? '0 : STEP_W'(r_build_d + 1'b1);

    smtd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DIV_W'(len_eff) * DIV_W'(div_d)),
        .i_divisor  (n_eff),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem_nz   (div_rem_nz)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_BUILD && div_done) begin
            r_tap_q[r_build_d]  <= div_quo[BUF_AW-1:0];
            r_tap_nz[r_build_d] <= div_rem_nz;
        end
    end

    // Gain memory.
    always_comb begin
        gain_wr.en    = accept && (i_opcode == OP_GAIN);
        gain_wr.row   = i_gain_row;
        gain_wr.col   = i_gain_column;
        gain_wr.level = i_gain_level;
    end

    assign issue = (r_state == S_WALK) && (r_row_cnt < N_W'(MAX_STEPS));

    smtd_gain u_gain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (gain_wr),
        .i_rd_addr ({r_step, r_row_cnt[STEP_W-1:0]}),
        .o_rd_data (gain_rd),
        .o_busy    (gain_busy)
    );

    // Step distance of a row and the resulting ring index.
    always_comb begin
        s_x  = (N_W+1)'(r_step);
        r_x  = (N_W+1)'(r_row1);
        sn_x = s_x + (N_W+1)'(n_eff);
        tap_fwd = 1'b0;
        if (r_x <= s_x) begin
            d_x = s_x - r_x;
        end else if (r_x <= sn_x) begin
            d_x = sn_x - r_x;
        end else begin
            d_x = r_x - sn_x;
            tap_fwd = 1'b1;
        end
        tap_d    = d_x[STEP_W-1:0];
        tap_back = LEN_W'(r_tap_q[tap_d]) + LEN_W'(r_tap_nz[tap_d]);
        if (tap_fwd) begin
            ring_idx = r_base + r_tap_q[tap_d];
        end else begin
            ring_idx = r_base - tap_back[BUF_AW-1:0];
        end
    end

    assign ring_we = accept && (i_opcode == OP_AUDIO);

    smtd_ring u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (ring_we),
        .i_left     (i_left_in),
        .i_right    (i_right_in),
        .i_rd_idx   (ring_idx),
        .o_rd_left  (ring_l),
        .o_rd_right (ring_r),
        .o_wp       (ring_wp)
    );

    assign out_free = !r_out_valid || !i_stall;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_dirty   <= 1'b1;
            r_phase   <= '0;
            r_build_d <= '0;
            r_row_cnt <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_NR_STEPS || i_cfg_idx == CFG_LOOP_LEN)) begin
                r_dirty <= 1'b1;
            end
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (issue) begin
                r_row_cnt <= r_row_cnt + 1'b1;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (!gain_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_BUILD: begin
                    if (div_done) begin
                        r_build_d <= STEP_W'(r_build_d + 1'b1);
                        if (r_build_d == STEP_W'(MAX_STEPS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (r_dirty) begin
                        if (!(i_cfg_we && (i_cfg_idx == CFG_NR_STEPS ||
                                           i_cfg_idx == CFG_LOOP_LEN))) begin
                            r_dirty <= 1'b0;
                        end
                        r_build_d <= '0;
                        r_state   <= S_BUILD;
                    end else if (accept) begin
                        unique case (i_opcode)
                            OP_AUDIO: begin
                                r_phase   <= r_phase + r_phase_inc;
                                r_row_cnt <= '0;
                                r_state   <= r_play ? S_WALK : S_MIX;
                            end
                            OP_PHASE: begin
                                r_phase <= i_new_phase;
                                r_state <= S_INFO;
                            end
                            default: r_state <= S_INFO;
                        endcase
                    end
                end
                S_WALK: begin
                    if (!issue && !r_v1 && !r_v2 && !r_v3) begin
                        r_state <= S_MIX;
                    end
                end
                S_MIX: r_state <= S_OUT;
                S_INFO: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_step  <= step_now;
            r_base  <= ring_wp;
            r_clamp <= (i_opcode == OP_GAIN) && gain_over(i_gain_level);
        end else if (r_state == S_INFO) begin
            r_step <= step_now;
        end
    end

    // Walk datapath: gain, ring read, products, accumulation.
    always_ff @(posedge i_clk) begin
        r_row1 <= r_row_cnt[STEP_W-1:0];
        r_g2   <= gain_rd;
        r_pl   <= 41'(signed'({1'b0, r_g2})) * 41'(signed'(ring_l));
        r_pr   <= 41'(signed'({1'b0, r_g2})) * 41'(signed'(ring_r));
        if (accept) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_v3) begin
            r_acc_l <= r_acc_l + ACC_W'(r_pl);
            r_acc_r <= r_acc_r + ACC_W'(r_pr);
        end
    end

    // Round to nearest and saturate to 24 bits.
    function automatic logic signed [23:0] mix_out(input logic signed [ACC_W-1:0] sum);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-16:0] q;
        t = sum + ACC_W'(16384);
        q = t[ACC_W-1:15];
        if (q > (ACC_W-15)'(8388607)) begin
            return 24'sd8388607;
        end else if (q < -(ACC_W-15)'(8388608)) begin
            return -24'sd8388608;
        end
        return q[23:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (r_state == S_MIX) begin
            r_res_l <= mix_out(r_acc_l);
            r_res_r <= mix_out(r_acc_r);
        end else if (r_state == S_INFO) begin
            r_res_l <= '0;
            r_res_r <= '0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_l     <= r_res_l;
            r_out_r     <= r_res_r;
            r_out_step  <= r_step;
            r_out_clamp <= r_clamp;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_left_out     = r_out_l;
    assign o_right_out    = r_out_r;
    assign o_current_step = r_out_step;
    assign o_gain_clamped = r_out_clamp;

`ifndef ASSERT_OFF
    // The ring is written only while the sequencer is idle.
    a_ring_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_we |-> r_state == S_IDLE)
        else $error("ring write outside idle");

    // An accepted transaction closes the input channel in the next cycle.
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall)
        else $error("input not stalled after accept");

    // A result waiting under stall is not overwritten by the next item.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> $stable(r_out_l) && $stable(r_out_step))
        else $error("stalled result overwritten");

    // The row counter never runs beyond the matrix.
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_cnt <= N_W'(MAX_STEPS))
        else $error("row counter overrun");
`endif

endmodule

>>> hw/rtl/smtd_div.sv
// Restoring divider that produces one quotient bit per cycle.
module smtd_div
    import smtd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [N_W-1:0]   i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quo,
    output logic             o_rem_nz
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [N_W-1:0]   r_rem;
    logic [N_W-1:0]   r_div;
    logic [N_W:0]     trial;

    // The partial remainder always stays below the divisor.
    assign trial = {r_rem, r_quo[DIV_W-1]};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift in one dividend bit and subtract where it fits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                r_rem <= N_W'(trial - {1'b0, r_div});
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[N_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done   = r_done;
    assign o_quo    = r_quo;
    assign o_rem_nz = (r_rem != '0);

endmodule

>>> hw/rtl/smtd_gain.sv
// Gain matrix memory with its reset sweep and the gain clamp.
module smtd_gain
    import smtd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_gain_wr           i_wr,
    input  logic [GAIN_AW-1:0] i_rd_addr,
    output logic [15:0]        o_rd_data,
    output logic               o_busy
);

    logic [15:0]        mem [2**GAIN_AW];
    logic [GAIN_AW:0]   r_clr_cnt;
    logic               r_busy;
    logic               we;
    logic [GAIN_AW-1:0] wa;
    logic [15:0]        wd;
    logic [15:0]        r_rd;

    // Sweep after reset writes unity on the diagonal and zero elsewhere.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == (GAIN_AW+1)'(2**GAIN_AW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Write port: the sweep while busy, otherwise the host write, clamped.
    always_comb begin
        if (r_busy) begin
            we = 1'b1;
            wa = r_clr_cnt[GAIN_AW-1:0];
            wd = (wa[GAIN_AW-1:STEP_W] == wa[STEP_W-1:0]) ? UNITY_GAIN : 16'd0;
        end else begin
            we = i_wr.en;
            wa = {i_wr.col, i_wr.row};
            wd = gain_over(i_wr.level) ? UNITY_GAIN : i_wr.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;
    assign o_busy    = r_busy;

endmodule

>>> hw/rtl/smtd_ring.sv
// Stereo ring buffer memory with write pointer and fill tracking.
module smtd_ring
    import smtd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [23:0]       i_left,
    input  logic [23:0]       i_right,
    input  logic [BUF_AW-1:0] i_rd_idx,
    output logic [23:0]       o_rd_left,
    output logic [23:0]       o_rd_right,
    output logic [BUF_AW-1:0] o_wp
);

    logic [47:0]       mem [BUFFER_DEPTH];
    logic [BUF_AW-1:0] r_wp;
    logic              r_wrapped;
    logic [47:0]       r_rd;
    logic              r_ok;

    // Pointer advances per sample; entries below it, or all after a wrap, are written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else if (i_we) begin
            r_wp <= r_wp + 1'b1;
            if (r_wp == BUF_AW'(BUFFER_DEPTH - 1)) begin
                r_wrapped <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[r_wp] <= {i_left, i_right};
        end
        r_rd <= mem[i_rd_idx];
        r_ok <= r_wrapped || (i_rd_idx < r_wp);
    end

    // Entries never written read as silence.
    assign o_rd_left  = r_ok ? r_rd[47:24] : 24'd0;
    assign o_rd_right = r_ok ? r_rd[23:0]  : 24'd0;
    assign o_wp       = r_wp;

endmodule
